/* rtl/kmsne_pkg.sv */
// ----------------------------------------------------------------------------
// kmsne_pkg: shared types and constants of the key matrix scanner
// Command codes, register indexes, reset values and the records passed
// between the command front end, the key store and the top level.
// ----------------------------------------------------------------------------
package kmsne_pkg;

   localparam int KEY_COUNT_DEFAULT = 64;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 8;
   localparam int NOTE_W  = 7;
   localparam int MS_W    = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESET_PULSE = 3'd0,
      CMD_CLOCK_PULSE = 3'd1,
      CMD_SUSTAIN     = 3'd2,
      CMD_SET_OUTPUT  = 3'd3,
      CMD_MS_TICK     = 3'd4
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD = 2'd2;

   localparam logic [NOTE_W-1:0] NOTE_OFFSET_RESET  = 7'd0;
   localparam logic [CFG_W-1:0]  IDLE_TIMEOUT_RESET = 16'd1000;
   localparam logic [CFG_W-1:0]  BLINK_PERIOD_RESET = 16'd250;

   // One accepted transaction as it leaves the front end.
   typedef struct packed {
      logic              visit;        // sample the key and drive the pin
      logic              in_range;     // scan position below the key count
      logic [POS_W-1:0]  pos;
      logic [NOTE_W-1:0] note_number;
      logic              level;
      logic              sustain;
      logic              set_out;      // store key_value at key_index
      logic [POS_W-1:0]  key_index;
      logic              key_value;
      logic              timeout_hit;  // idle timeout fired: pin goes low
      logic              led;
   } slot_type;

   typedef struct packed {
      logic              note_valid;
      logic [NOTE_W-1:0] note_number;
      logic              note_on;
      logic              key_out_level;
      logic              led_level;
   } result_type;

endpackage

/* rtl/kmsne_front.sv */
// ----------------------------------------------------------------------------
// kmsne_front: command decode and scalar state
// Holds the configuration registers, scan position, sustain, timeout and
// blink state, and turns each accepted transaction into a slot record.
// ----------------------------------------------------------------------------
module kmsne_front #(
   parameter int KEY_COUNT = kmsne_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [kmsne_pkg::CMD_W-1:0]         cmd,
   input  logic                                key_level,
   input  logic                                pedal_pin,
   input  logic [kmsne_pkg::POS_W-1:0]         key_index,
   input  logic                                key_value,
   input  logic                                csr_write_enable,
   input  logic [kmsne_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kmsne_pkg::CFG_W-1:0]         csr_wdata,
   output kmsne_pkg::slot_type                 slot
);

   logic [kmsne_pkg::NOTE_W-1:0] note_offset_ff;
   logic [kmsne_pkg::CFG_W-1:0]  idle_timeout_ff;
   logic [kmsne_pkg::CFG_W-1:0]  blink_period_ff;

   logic [kmsne_pkg::POS_W-1:0] scan_pos_ff, scan_pos_in;
   logic                        sustain_ff, sustain_in;
   logic                        timed_out_ff, timed_out_in;
   logic                        blink_ff, blink_in;
   logic                        led_ff, led_in;
   logic [kmsne_pkg::MS_W-1:0]  ms_reset_ff, ms_reset_in;
   logic [kmsne_pkg::MS_W-1:0]  ms_blink_ff, ms_blink_in;

   logic visit;
   logic set_out;
   logic timeout_hit;

   always_comb begin
      scan_pos_in  = scan_pos_ff;
      sustain_in   = sustain_ff;
      timed_out_in = timed_out_ff;
      blink_in     = blink_ff;
      led_in       = led_ff;
      ms_reset_in  = ms_reset_ff;
      ms_blink_in  = ms_blink_ff;
      visit        = 1'b0;
      set_out      = 1'b0;
      timeout_hit  = 1'b0;
      unique case (kmsne_pkg::cmd_type'(cmd))
         kmsne_pkg::CMD_RESET_PULSE: begin
            ms_reset_in = '0;
            if (timed_out_ff) begin
               timed_out_in = 1'b0;
               blink_in     = 1'b0;
               led_in       = 1'b1;
            end
            scan_pos_in = '0;
            visit       = 1'b1;
         end
         kmsne_pkg::CMD_CLOCK_PULSE: begin
            if (!timed_out_ff) begin
               scan_pos_in = scan_pos_ff + 1'b1;
               visit       = 1'b1;
            end
         end
         kmsne_pkg::CMD_SUSTAIN: begin
            sustain_in = !pedal_pin;
         end
         kmsne_pkg::CMD_SET_OUTPUT: begin
            set_out = (key_index < kmsne_pkg::POS_W'(KEY_COUNT));
         end
         kmsne_pkg::CMD_MS_TICK: begin
            ms_reset_in = (ms_reset_ff == '1) ? ms_reset_ff : ms_reset_ff + 1'b1;
            ms_blink_in = (ms_blink_ff == '1) ? ms_blink_ff : ms_blink_ff + 1'b1;
            // The incremented count exceeds the limit exactly when the old
            // count has reached it, saturation included.
            if (timed_out_ff) begin
               if (ms_blink_ff >= kmsne_pkg::MS_W'(blink_period_ff)) begin
                  ms_blink_in = '0;
                  blink_in    = !blink_ff;
                  led_in      = !blink_ff;
               end
            end else if (ms_reset_ff >= kmsne_pkg::MS_W'(idle_timeout_ff)) begin
               timed_out_in = 1'b1;
               timeout_hit  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      slot.visit       = visit;
      slot.in_range    = (scan_pos_in < kmsne_pkg::POS_W'(KEY_COUNT));
      slot.pos         = scan_pos_in;
      slot.note_number = scan_pos_in[kmsne_pkg::NOTE_W-1:0] + note_offset_ff;
      slot.level       = key_level;
      slot.sustain     = sustain_ff;
      slot.set_out     = set_out;
      slot.key_index   = key_index;
      slot.key_value   = key_value;
      slot.timeout_hit = timeout_hit;
      slot.led         = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff  <= '0;
         sustain_ff   <= 1'b0;
         timed_out_ff <= 1'b1;
         blink_ff     <= 1'b1;
         led_ff       <= 1'b0;
         ms_reset_ff  <= '0;
         ms_blink_ff  <= '0;
      end else if (accept) begin
         scan_pos_ff  <= scan_pos_in;
         sustain_ff   <= sustain_in;
         timed_out_ff <= timed_out_in;
         blink_ff     <= blink_in;
         led_ff       <= led_in;
         ms_reset_ff  <= ms_reset_in;
         ms_blink_ff  <= ms_blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_offset_ff  <= kmsne_pkg::NOTE_OFFSET_RESET;
         idle_timeout_ff <= kmsne_pkg::IDLE_TIMEOUT_RESET;
         blink_period_ff <= kmsne_pkg::BLINK_PERIOD_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == kmsne_pkg::CSR_NOTE_OFFSET) begin
            note_offset_ff <= csr_wdata[kmsne_pkg::NOTE_W-1:0];
         end
         if (csr_index == kmsne_pkg::CSR_IDLE_TIMEOUT) begin
            idle_timeout_ff <= csr_wdata;
         end
         if (csr_index == kmsne_pkg::CSR_BLINK_PERIOD) begin
            blink_period_ff <= csr_wdata;
         end
      end
   end

endmodule

/* rtl/kmsne_key_store.sv */
// ----------------------------------------------------------------------------
// kmsne_key_store: per-key input and output level memories
// Reads both memories as a transaction is accepted, works out the note event
// and the pin level from the registered read data, and writes back as the slot advances.
// ----------------------------------------------------------------------------
module kmsne_key_store #(
   parameter int KEY_COUNT = kmsne_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  kmsne_pkg::slot_type    slot_next,
   input  logic                   advance,
   output logic                   clearing,
   output kmsne_pkg::result_type  result
);

   localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   logic in_mem  [KEY_COUNT];
   logic out_mem [KEY_COUNT];

   logic          clear_ff;
   logic [AW-1:0] clear_cnt_ff;

   kmsne_pkg::slot_type slot_ff;
   logic in_rd_ff, out_rd_ff;
   logic fwd_in_hit_ff, fwd_in_val_ff;
   logic fwd_out_hit_ff, fwd_out_val_ff;
   logic pin_ff, pin_in;

   logic [AW-1:0] raddr;
   logic [AW-1:0] s1_addr, s1_kaddr;
   logic          in_old, out_old, new_in, event_hit;
   logic          s1_in_we, s1_out_we;
   logic          in_we, out_we;
   logic [AW-1:0] in_waddr, out_waddr;
   logic          in_wdata, out_wdata;

   assign raddr    = slot_next.pos[AW-1:0];
   assign s1_addr  = slot_ff.pos[AW-1:0];
   assign s1_kaddr = slot_ff.key_index[AW-1:0];

   // A write from the slot ahead lands on the same edge as the read, so its
   // value is captured beside the read data and preferred over it.
   assign in_old  = fwd_in_hit_ff  ? fwd_in_val_ff  : in_rd_ff;
   assign out_old = fwd_out_hit_ff ? fwd_out_val_ff : out_rd_ff;

   assign event_hit = slot_ff.visit && slot_ff.in_range && (in_old != slot_ff.level)
                      && !(slot_ff.sustain && !slot_ff.level);
   assign new_in    = event_hit ? slot_ff.level : in_old;

   always_comb begin
      priority if (slot_ff.visit) begin
         pin_in = slot_ff.in_range && (out_old || (slot_ff.sustain && new_in));
      end else if (slot_ff.timeout_hit) begin
         pin_in = 1'b0;
      end else begin
         pin_in = pin_ff;
      end
   end

   assign s1_in_we  = advance && event_hit;
   assign s1_out_we = advance && slot_ff.set_out;

   assign in_we     = clear_ff || s1_in_we;
   assign in_waddr  = clear_ff ? clear_cnt_ff : s1_addr;
   assign in_wdata  = !clear_ff && slot_ff.level;
   assign out_we    = clear_ff || s1_out_we;
   assign out_waddr = clear_ff ? clear_cnt_ff : s1_kaddr;
   assign out_wdata = !clear_ff && slot_ff.key_value;

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_waddr] <= in_wdata;
      end
      if (out_we) begin
         out_mem[out_waddr] <= out_wdata;
      end
      if (accept) begin
         in_rd_ff  <= in_mem[raddr];
         out_rd_ff <= out_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff        <= slot_next;
         fwd_in_hit_ff  <= s1_in_we && (s1_addr == raddr);
         fwd_in_val_ff  <= slot_ff.level;
         fwd_out_hit_ff <= s1_out_we && (s1_kaddr == raddr);
         fwd_out_val_ff <= slot_ff.key_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         pin_ff       <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == AW'(KEY_COUNT - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (advance) begin
            pin_ff <= pin_in;
         end
      end
   end

   assign clearing = clear_ff;

   always_comb begin
      result.note_valid    = event_hit;
      result.note_number   = event_hit ? slot_ff.note_number : '0;
      result.note_on       = event_hit && slot_ff.level;
      result.key_out_level = pin_in;
      result.led_level     = slot_ff.led;
   end

endmodule

/* rtl/key_matrix_scan_note_events.sv */
// ----------------------------------------------------------------------------
// key_matrix_scan_note_events: serial keyboard scanner with note events
// Follows a serial key scan bus, reports key changes as note events, drives
// the key output pin and runs an idle timeout with a blinking status LED.
// ----------------------------------------------------------------------------
// Every transaction gives exactly one result, and one transaction is taken
// each cycle while the result side keeps up; a transaction passes the first
// stage register and then the result register. The per-key levels sit in
// two memories, each with one read and one write port, read on acceptance
// and written back as it leaves the first stage, with forwarding between
// neighbouring transactions. After reset the block clears both memories and
// stalls the request side meanwhile; register writes are taken throughout.
module key_matrix_scan_note_events #(
   parameter int KEY_COUNT = kmsne_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kmsne_pkg::CMD_W-1:0]       req_cmd,
   input  logic                              req_key_level,
   input  logic                              req_pedal_pin,
   input  logic [kmsne_pkg::POS_W-1:0]       req_key_index,
   input  logic                              req_key_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_note_valid,
   output logic [kmsne_pkg::NOTE_W-1:0]      rsp_note_number,
   output logic                              rsp_note_on,
   output logic                              rsp_key_out_level,
   output logic                              rsp_led_level,
   input  logic                              csr_write_enable,
   input  logic [kmsne_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kmsne_pkg::CFG_W-1:0]       csr_wdata
);

   kmsne_pkg::slot_type   slot_next;
   kmsne_pkg::result_type result;
   kmsne_pkg::result_type rsp_ff;

   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic clearing;
   logic out_free, s1_free, accept, advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = clearing || !s1_free;
   assign accept    = req_valid && !req_stall;
   assign advance   = s1_valid_ff && out_free;

   kmsne_front #(.KEY_COUNT(KEY_COUNT)) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .cmd              (req_cmd),
      .key_level        (req_key_level),
      .pedal_pin        (req_pedal_pin),
      .key_index        (req_key_index),
      .key_value        (req_key_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .slot             (slot_next)
   );

   kmsne_key_store #(.KEY_COUNT(KEY_COUNT)) u_key_store (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .slot_next (slot_next),
      .advance   (advance),
      .clearing  (clearing),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_note_valid    = rsp_ff.note_valid;
   assign rsp_note_number   = rsp_ff.note_number;
   assign rsp_note_on       = rsp_ff.note_on;
   assign rsp_key_out_level = rsp_ff.key_out_level;
   assign rsp_led_level     = rsp_ff.led_level;

endmodule

/* rtl/kmsne_checker.sv */
// ----------------------------------------------------------------------------
// kmsne_checker: port-level checks for the key matrix scanner
// Watches the top-level ports for reset behaviour, result consistency and
// the hold rule of the result channel.
// ----------------------------------------------------------------------------
module kmsne_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_note_valid,
   input logic [kmsne_pkg::NOTE_W-1:0]      rsp_note_number,
   input logic                              rsp_note_on,
   input logic                              rsp_key_out_level,
   input logic                              rsp_led_level
);

   // The memory clearing sweep keeps requests out straight after reset.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request side open straight after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // A result without a note carries a cleared note number and flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_note_valid) |-> (rsp_note_number == '0 && !rsp_note_on))
      else $error("note fields set on a result without a note");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_note_valid)
         && $stable(rsp_note_number) && $stable(rsp_note_on)
         && $stable(rsp_key_out_level) && $stable(rsp_led_level)))
      else $error("stalled result changed");

endmodule

bind key_matrix_scan_note_events kmsne_checker u_kmsne_checker (.*);

/* sim/tb_key_matrix_scan_note_events.sv */
// ----------------------------------------------------------------------------
// tb_key_matrix_scan_note_events: self-checking bench for the key scanner
// Drives scan bus commands through the valid/stall request channel, predicts
// every note event, key pin and LED level in a scoreboard class and checks
// each response in order, across several register settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_key_matrix_scan_note_events;
   import kmsne_pkg::*;

   localparam int KEYS           = KEY_COUNT_DEFAULT;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 280;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_AFTER     = 1300;
   localparam int HOLD_CYCLES    = 200;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CMD_W-1:0] CMD_UNUSED_LOW  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HIGH = 3'd7;

   class note_event_checker;
      logic [NOTE_W-1:0] note_offset  = NOTE_OFFSET_RESET;
      logic [CFG_W-1:0]  idle_timeout = IDLE_TIMEOUT_RESET;
      logic [CFG_W-1:0]  blink_period = BLINK_PERIOD_RESET;
      bit                in_level  [KEYS];
      bit                out_level [KEYS];
      logic [POS_W-1:0]  scan_pos = '0;
      bit                sustain = 1'b0;
      bit                timed_out = 1'b1;
      bit                blink_phase = 1'b1;
      bit                led = 1'b0;
      bit                pin = 1'b0;
      logic [MS_W-1:0]   ms_reset = '0;
      logic [MS_W-1:0]   ms_blink = '0;
      result_type        pending_results [$];
      int                checked = 0;
      int                mismatches = 0;
      int                note_events = 0;
      int                timeouts = 0;
      int                toggles = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_NOTE_OFFSET:  note_offset  = value[NOTE_W-1:0];
            CSR_IDLE_TIMEOUT: idle_timeout = value;
            CSR_BLINK_PERIOD: blink_period = value;
            default: ;
         endcase
      endfunction

      // Samples the key at the current position and drives the key pin.
      function result_type sample_key(bit level);
         result_type r;
         r = '0;
         pin = 1'b0;
         if (scan_pos < KEYS) begin
            // A release is held back while the sustain pedal is down.
            if (in_level[scan_pos] != level && !(sustain && !level)) begin
               r.note_valid  = 1'b1;
               r.note_number = scan_pos[NOTE_W-1:0] + note_offset;
               r.note_on     = level;
               in_level[scan_pos] = level;
            end
            pin = sustain ? (in_level[scan_pos] | out_level[scan_pos]) : out_level[scan_pos];
         end
         return r;
      endfunction

      // Returns 1 when the transaction had any effect on the block.
      function bit apply_transaction(logic [CMD_W-1:0] cmd, logic level, logic pedal,
                                     logic [POS_W-1:0] kidx, logic kval);
         result_type want;
         bit acted;
         want  = '0;
         acted = 1'b1;
         case (cmd)
            CMD_RESET_PULSE: begin
               ms_reset = '0;
               if (timed_out) begin
                  blink_phase = 1'b0;
                  timed_out   = 1'b0;
                  led         = 1'b1;
               end
               scan_pos = '0;
               want = sample_key(level);
            end
            CMD_CLOCK_PULSE: begin
               if (timed_out) begin
                  acted = 1'b0;
               end else begin
                  scan_pos = scan_pos + 1'b1;
                  want = sample_key(level);
               end
            end
            CMD_SUSTAIN: sustain = !pedal;
            CMD_SET_OUTPUT: begin
               if (kidx < KEYS) out_level[kidx] = kval;
               else acted = 1'b0;
            end
            CMD_MS_TICK: begin
               if (ms_reset != '1) ms_reset = ms_reset + 1'b1;
               if (ms_blink != '1) ms_blink = ms_blink + 1'b1;
               if (timed_out) begin
                  if (ms_blink > MS_W'(blink_period)) begin
                     ms_blink    = '0;
                     blink_phase = !blink_phase;
                     led         = blink_phase;
                     toggles++;
                  end
               end else if (ms_reset > MS_W'(idle_timeout)) begin
                  timed_out = 1'b1;
                  pin       = 1'b0;
                  timeouts++;
               end
            end
            default: acted = 1'b0;
         endcase
         want.key_out_level = pin;
         want.led_level     = led;
         if (want.note_valid) note_events++;
         pending_results.push_back(want);
         return acted;
      endfunction

      function void check_result(result_type seen);
         result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Response %0d arrived with no transaction outstanding", checked);
            return;
         end
         want = pending_results.pop_front();
         if (seen.note_valid !== want.note_valid || seen.note_number !== want.note_number ||
             seen.note_on !== want.note_on || seen.key_out_level !== want.key_out_level ||
             seen.led_level !== want.led_level) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"Response %0d: expected note=%b/%0d/%b pin=%b led=%b, ",
                         "got note=%b/%0d/%b pin=%b led=%b"},
                        checked, want.note_valid, want.note_number, want.note_on,
                        want.key_out_level, want.led_level, seen.note_valid,
                        seen.note_number, seen.note_on, seen.key_out_level, seen.led_level);
         end
      endfunction

      function int leftover();
         if (pending_results.size() != 0)
            $display("%0d responses never arrived", pending_results.size());
         return pending_results.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic                 req_key_level = 1'b0;
   logic                 req_pedal_pin = 1'b0;
   logic [POS_W-1:0]     req_key_index = '0;
   logic                 req_key_value = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_note_valid;
   logic [NOTE_W-1:0]    rsp_note_number;
   logic                 rsp_note_on;
   logic                 rsp_key_out_level;
   logic                 rsp_led_level;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   note_event_checker scan_model;
   int unsigned       req_idle_pct = 0;
   int unsigned       rsp_idle_pct = 0;
   int                accepted_count = 0;
   int                useful_count = 0;
   int                settings_count = 0;
   int                idle_cycles = 0;
   int                hold_left = 0;
   bit                hold_used = 1'b0;

   key_matrix_scan_note_events u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_key_level     (req_key_level),
      .req_pedal_pin     (req_pedal_pin),
      .req_key_index     (req_key_index),
      .req_key_value     (req_key_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_note_valid    (rsp_note_valid),
      .rsp_note_number   (rsp_note_number),
      .rsp_note_on       (rsp_note_on),
      .rsp_key_out_level (rsp_key_out_level),
      .rsp_led_level     (rsp_led_level),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic level, input logic pedal,
                            input logic [POS_W-1:0] kidx, input logic kval);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_key_level <= level;
      req_pedal_pin <= pedal;
      req_key_index <= kidx;
      req_key_value <= kval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_count++;
      if (scan_model.apply_transaction(cmd, level, pedal, kidx, kval)) useful_count++;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random(input logic [CMD_W-1:0] cmd);
      logic [POS_W-1:0] kidx;
      // Mostly keys that exist, now and then any index at all.
      kidx = ($urandom_range(4) == 0) ? POS_W'($urandom_range(255))
                                      : POS_W'($urandom_range(KEYS - 1));
      send_item(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)), kidx, 1'($urandom_range(1)));
   endtask

   task automatic set_config(input logic [NOTE_W-1:0] offset, input logic [CFG_W-1:0] timeout_ms,
                             input logic [CFG_W-1:0] period_ms);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NOTE_OFFSET;
      csr_wdata        <= CFG_W'(offset);
      @(posedge clock);
      csr_index        <= CSR_IDLE_TIMEOUT;
      csr_wdata        <= timeout_ms;
      @(posedge clock);
      csr_index        <= CSR_BLINK_PERIOD;
      csr_wdata        <= period_ms;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scan_model.write_reg(CSR_NOTE_OFFSET, CFG_W'(offset));
      scan_model.write_reg(CSR_IDLE_TIMEOUT, timeout_ms);
      scan_model.write_reg(CSR_BLINK_PERIOD, period_ms);
      settings_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scan_model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Most of the traffic is a reset pulse followed by a scan with random key
   // levels, mixed with pedal, output and tick commands; tick bursts reach the
   // timeout and the blinking, and single random commands add noise.
   task automatic run_random(input int quota);
      int stop_at;
      int kind;
      int scan_len;
      stop_at = accepted_count + quota;
      while (accepted_count < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            send_random(CMD_RESET_PULSE);
            scan_len = ($urandom_range(9) == 0) ? $urandom_range(200, 300)
                                                : $urandom_range(1, 60);
            while (scan_len > 0 && accepted_count < stop_at) begin
               case ($urandom_range(19))
                  0:       send_random(CMD_MS_TICK);
                  1:       send_random(CMD_SUSTAIN);
                  2, 3:    send_random(CMD_SET_OUTPUT);
                  default: send_random(CMD_CLOCK_PULSE);
               endcase
               scan_len--;
            end
         end else if (kind < 80) begin
            scan_len = $urandom_range(5, 40);
            while (scan_len > 0 && accepted_count < stop_at) begin
               send_random(CMD_MS_TICK);
               scan_len--;
            end
         end else begin
            send_random(CMD_W'($urandom_range(7)));
         end
      end
   endtask

   // Response side: checks each transaction and stalls at random, with one
   // long hold-off so that the block backs up onto its request side.
   always @(posedge clock) begin
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_note_valid, rsp_note_number, rsp_note_on, rsp_key_out_level, rsp_led_level};
         scan_model.check_result(seen);
      end
      if (!hold_used && scan_model.checked >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_used = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int failures;
      scan_model = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: starts timed out, with the offset at its top value so
      // that note numbers wrap, a short timeout and a blink on every tick.
      set_config(7'd127, 16'd2, 16'd0);
      send_item(CMD_CLOCK_PULSE, 1'b1, 1'b0, 8'd0, 1'b0);    // ignored while timed out
      send_item(CMD_MS_TICK, 1'b0, 1'b0, 8'd0, 1'b0);
      send_item(CMD_MS_TICK, 1'b1, 1'b1, 8'd255, 1'b1);
      send_item(CMD_SET_OUTPUT, 1'b0, 1'b0, 8'd0, 1'b1);
      send_item(CMD_SET_OUTPUT, 1'b0, 1'b0, 8'd255, 1'b1);   // beyond the key count
      send_item(CMD_SET_OUTPUT, 1'b0, 1'b0, 8'd64, 1'b1);
      send_item(CMD_SET_OUTPUT, 1'b0, 1'b0, 8'd63, 1'b1);
      send_item(CMD_RESET_PULSE, 1'b1, 1'b0, 8'd0, 1'b0);
      send_item(CMD_CLOCK_PULSE, 1'b0, 1'b0, 8'd0, 1'b0);
      send_item(CMD_SUSTAIN, 1'b0, 1'b0, 8'd0, 1'b0);        // pedal down
      send_item(CMD_RESET_PULSE, 1'b0, 1'b0, 8'd0, 1'b0);    // release held back
      send_item(CMD_CLOCK_PULSE, 1'b1, 1'b0, 8'd0, 1'b0);
      send_item(CMD_SUSTAIN, 1'b1, 1'b1, 8'd0, 1'b0);        // pedal up
      send_item(CMD_RESET_PULSE, 1'b0, 1'b0, 8'd0, 1'b0);
      send_item(CMD_CLOCK_PULSE, 1'b0, 1'b0, 8'd0, 1'b0);
      send_item(CMD_UNUSED_HIGH, 1'b1, 1'b1, 8'd255, 1'b1);
      send_item(CMD_UNUSED_LOW, 1'b0, 1'b0, 8'd0, 1'b0);
      repeat (3) send_item(CMD_MS_TICK, 1'b0, 1'b0, 8'd0, 1'b0);
      send_item(CMD_CLOCK_PULSE, 1'b1, 1'b0, 8'd1, 1'b0);
      send_item(CMD_RESET_PULSE, 1'b1, 1'b1, 8'd0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       set_config(7'd64, 16'd0, 16'd0);
            1:       set_config(NOTE_W'($urandom_range(127)), 16'd30, 16'd3);
            2:       set_config(7'd0, 16'hFFFF, 16'hFFFF);
            3:       set_config(NOTE_W'($urandom_range(127)), 16'd12, 16'd1);
            4:       set_config(7'd1, 16'd200, 16'd7);
            default: set_config(NOTE_W'($urandom_range(127)), CFG_W'($urandom_range(50)),
                                CFG_W'($urandom_range(20)));
         endcase
         req_idle_pct <= (phase < 2) ? 32 : (phase < 4) ? 83 : 0;
         rsp_idle_pct <= (phase < 2) ? 83 : (phase < 4) ? 32 : 0;
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      failures = scan_model.mismatches + scan_model.leftover();
      $display("Covered %0d transactions (%0d with effect) under %0d register settings.",
               accepted_count, useful_count, settings_count);
      $display("Saw %0d note events, %0d idle timeouts and %0d LED toggles; %0d mismatches.",
               scan_model.note_events, scan_model.timeouts, scan_model.toggles,
               scan_model.mismatches);
      if (failures == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
